/* rtl/core/mtwg_pkg.sv */
`default_nettype none

package mtwg_pkg;

	localparam int STATE_WORDS   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int SPLIT_BIT     = 31;

	localparam int ADDR_W = $clog2(STATE_WORDS);
	localparam int IDX_W  = $clog2(STATE_WORDS + 1);

	localparam int PARTNER_INIT = MIDDLE_OFFSET % STATE_WORDS;

	localparam logic [31:0] FILL_MULT = 32'd29943829;
	localparam logic [31:0] LOW_MASK  = (32'd1 << SPLIT_BIT) - 32'd1;
	localparam logic [31:0] HIGH_MASK = ~LOW_MASK;

	localparam logic [31:0] TWIST_MATRIX_RST  = 32'h9908B0DF;
	localparam logic [31:0] TEMPER_MASK_B_RST = 32'h9D2C5680;
	localparam logic [31:0] TEMPER_MASK_C_RST = 32'hEFC60000;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TWIST_MATRIX  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPER_MASK_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPER_MASK_C = 2'd2;

	localparam logic OP_SEED = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	typedef struct packed {
		logic [31:0] twist_matrix;
		logic [31:0] temper_mask_b;
		logic [31:0] temper_mask_c;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		UOP_FILL   = 3'b001,
		UOP_TWIST  = 3'b010,
		UOP_TEMPER = 3'b100
	} unit_op_t;

endpackage

`default_nettype wire

/* rtl/core/mtwg_ram.sv */
`default_nettype none

module mtwg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

/* rtl/core/mtwg_unit.sv */
`default_nettype none

module mtwg_unit
	import mtwg_pkg::*;
(
	input  wire unit_op_t    op,
	input  wire cfg_regs_t   cfg,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] c,
	output      logic [31:0] res
);

	logic [31:0] fill_prod;
	logic [31:0] y_twist;
	logic [31:0] v_twist;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] t3;
	logic [31:0] t4;

	// fill step: s * mult - 1, low 32 bits
	assign fill_prod = a * FILL_MULT;

	// twist: upper bits of this word, lower bits of the next one
	assign y_twist = (a & HIGH_MASK) | (b & LOW_MASK);
	assign v_twist = c ^ (y_twist >> 1) ^ (y_twist[0] ? cfg.twist_matrix : 32'd0);

	assign t1 = a  ^ (a >> 11);
	assign t2 = t1 ^ ((t1 << 7) & cfg.temper_mask_b);
	assign t3 = t2 ^ ((t2 << 15) & cfg.temper_mask_c);
	assign t4 = t3 ^ (t3 >> 18);

	always_comb begin
		unique case (op)
			UOP_FILL:   res = fill_prod - 32'd1;
			UOP_TWIST:  res = v_twist;
			UOP_TEMPER: res = t4;
			default:    res = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/mersenne_twister_word_generator.sv */
`default_nettype none

// Mersenne Twister word generator, 32-bit words, MT19937 recurrence.
// Command channel: start with operation and seed_value is taken when busy is
// low. A seed fills the word store from the seed and returns nothing; a draw
// returns one tempered word on random_word, flagged by result_valid for one
// cycle. The receiver cannot stall; every result must be taken when shown.
// Sequence after a start is accepted:
//   seed: busy while all STATE_WORDS (624) words are filled, one fill multiply per word.
//   draw: result_valid rises as the generator returns to idle, the next start taken in that cycle.
//   a draw that finds the store used up first regenerates every word, with
//   three reads and one write per word on the single memory port.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write the
// twist matrix (0) and the two tempering masks (1, 2); other indexes are
// dropped. cfg_ready is always high; write only while busy is low.
// Reset restores the register defaults and marks the store used up. The store
// holds nothing valid until a seed: seed before the first draw.

module mersenne_twister_word_generator
	import mtwg_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output      logic                 busy,
	input  wire logic                 operation,
	input  wire logic [31:0]          seed_value,
	output      logic                 result_valid,
	output      logic [31:0]          random_word,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_FILL      = 9'b000000010,
		ST_GEN_RK    = 9'b000000100,
		ST_GEN_RN    = 9'b000001000,
		ST_GEN_RP    = 9'b000010000,
		ST_GEN_WR    = 9'b000100000,
		ST_DRAW_RD   = 9'b001000000,
		ST_DRAW_OUT  = 9'b010000000,
		ST_SPARE     = 9'b100000000
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STATE_WORDS - 1);
	localparam logic [ADDR_W-1:0] PARTNER_RST  = ADDR_W'(PARTNER_INIT);
	localparam logic [IDX_W-1:0]  IDX_EMPTY    = IDX_W'(STATE_WORDS);

	state_t              state_q;
	cfg_regs_t           cfg_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [ADDR_W-1:0]   k_q;
	logic [ADDR_W-1:0]   partner_q;
	logic [31:0]         s_q;
	logic [31:0]         cur_q;
	logic [31:0]         nxt_q;
	logic                valid_q;
	logic [31:0]         word_q;

	logic [ADDR_W-1:0]   k_next;
	logic [ADDR_W-1:0]   partner_next;
	logic                accept;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [31:0]         ram_rdata;
	unit_op_t            uop;
	logic [31:0]         ua;
	logic [31:0]         unit_res;

	assign accept       = start && (state_q == ST_IDLE);
	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = valid_q;
	assign random_word  = word_q;

	assign k_next       = (k_q == LAST_ADDR) ? '0 : k_q + ADDR_W'(1);
	assign partner_next = (partner_q == LAST_ADDR) ? '0 : partner_q + ADDR_W'(1);

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = k_q;
		uop      = UOP_TEMPER;
		ua       = ram_rdata;
		unique case (state_q)
			ST_FILL: begin
				ram_we = 1'b1;
				uop    = UOP_FILL;
				ua     = s_q;
			end
			ST_GEN_RN:   ram_addr = k_next;
			ST_GEN_RP:   ram_addr = partner_q;
			ST_GEN_WR: begin
				ram_we = 1'b1;
				uop    = UOP_TWIST;
				ua     = cur_q;
			end
			ST_DRAW_RD:  ram_addr = rd_idx_q[ADDR_W-1:0];
			default: begin
			end
		endcase
	end

	mtwg_unit u_unit (
		.op  (uop),
		.cfg (cfg_q),
		.a   (ua),
		.b   (nxt_q),
		.c   (ram_rdata),
		.res (unit_res)
	);

	mtwg_ram #(
		.WIDTH (32),
		.DEPTH (STATE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (unit_res),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.twist_matrix  <= TWIST_MATRIX_RST;
			cfg_q.temper_mask_b <= TEMPER_MASK_B_RST;
			cfg_q.temper_mask_c <= TEMPER_MASK_C_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TWIST_MATRIX:  cfg_q.twist_matrix  <= cfg_data;
				CFG_TEMPER_MASK_B: cfg_q.temper_mask_b <= cfg_data;
				CFG_TEMPER_MASK_C: cfg_q.temper_mask_c <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= IDX_EMPTY;
			k_q       <= '0;
			partner_q <= PARTNER_RST;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q       <= '0;
						partner_q <= PARTNER_RST;
						if (operation == OP_SEED) begin
							state_q <= ST_FILL;
						end else if (rd_idx_q >= IDX_EMPTY) begin
							state_q <= ST_GEN_RK;
						end else begin
							state_q <= ST_DRAW_RD;
						end
					end
				end
				ST_FILL: begin
					k_q <= k_next;
					if (k_q == LAST_ADDR) begin
						rd_idx_q <= IDX_EMPTY;
						state_q  <= ST_IDLE;
					end
				end
				ST_GEN_RK:   state_q <= ST_GEN_RN;
				ST_GEN_RN:   state_q <= ST_GEN_RP;
				ST_GEN_RP:   state_q <= ST_GEN_WR;
				ST_GEN_WR: begin
					k_q       <= k_next;
					partner_q <= partner_next;
					if (k_q == LAST_ADDR) begin
						rd_idx_q <= '0;
						state_q  <= ST_DRAW_RD;
					end else begin
						state_q <= ST_GEN_RK;
					end
				end
				ST_DRAW_RD:  state_q <= ST_DRAW_OUT;
				ST_DRAW_OUT: begin
					valid_q  <= 1'b1;
					rd_idx_q <= rd_idx_q + IDX_W'(1);
					state_q  <= ST_IDLE;
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath holding registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= seed_value;
		end else if (state_q == ST_FILL) begin
			s_q <= unit_res;
		end
		if (state_q == ST_GEN_RN) begin
			cur_q <= ram_rdata;
		end
		if (state_q == ST_GEN_RP) begin
			nxt_q <= ram_rdata;
		end
		if (state_q == ST_DRAW_OUT) begin
			word_q <= unit_res;
		end
	end

	a_result_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW_OUT) |=> result_valid)
		else $error("draw read did not produce a result strobe");

	a_result_only_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_DRAW_OUT))
		else $error("result strobe without a draw read");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= IDX_EMPTY)
		else $error("read index past store size");

	a_fast_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_DRAW && rd_idx_q < IDX_EMPTY) |=>
		(state_q == ST_DRAW_RD))
		else $error("draw with words left did not go straight to read");

	a_regen_ends_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN_WR && k_q == LAST_ADDR) |=>
		(state_q == ST_DRAW_RD && rd_idx_q == '0))
		else $error("regeneration did not restart the read index");

endmodule

`default_nettype wire

/* tb/mtwg_checker.sv */
`default_nettype none

module mtwg_checker import mtwg_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic                 operation,
	input  wire logic [31:0]          seed_value,
	input  wire logic                 result_valid,
	input  wire logic [31:0]          random_word,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	output int                        mismatches,
	output int                        pending,
	output int                        words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] store_copy [STATE_WORDS];
	int          next_read;
	logic [31:0] twist_reg;
	logic [31:0] mask_b_reg;
	logic [31:0] mask_c_reg;
	logic [31:0] expected_words [$];
	logic [31:0] want;
	int          fail_count;
	int          checked_count;

	function automatic logic [31:0] temper_word(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y ^= y >> 11;
		y ^= (y << 7) & mask_b_reg;
		y ^= (y << 15) & mask_c_reg;
		y ^= y >> 18;
		return y;
	endfunction

	function automatic void fill_from_seed(input logic [31:0] seed);
		logic [31:0] s;
		s = seed;
		for (int k = 0; k < STATE_WORDS; k++) begin
			s = s * FILL_MULT - 32'd1;
			store_copy[k] = s;
		end
		next_read = STATE_WORDS;
	endfunction

	// in-place batch twist: late partners read words already rewritten
	function automatic void twist_all();
		logic [31:0] lo_bits;
		logic [31:0] hi_bits;
		logic [31:0] y;
		logic [31:0] v;
		int          partner;
		int          nxt;
		lo_bits = (32'd1 << SPLIT_BIT) - 32'd1;
		hi_bits = ~lo_bits;
		partner = MIDDLE_OFFSET % STATE_WORDS;
		for (int k = 0; k < STATE_WORDS; k++) begin
			nxt = (k + 1 == STATE_WORDS) ? 0 : k + 1;
			y = (store_copy[k] & hi_bits) | (store_copy[nxt] & lo_bits);
			v = store_copy[partner] ^ (y >> 1);
			if (y[0])
				v ^= twist_reg;
			store_copy[k] = v;
			partner = (partner + 1 == STATE_WORDS) ? 0 : partner + 1;
		end
		next_read = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			next_read = STATE_WORDS;
			twist_reg = TWIST_MATRIX_RST;
			mask_b_reg = TEMPER_MASK_B_RST;
			mask_c_reg = TEMPER_MASK_C_RST;
			fail_count = 0;
			checked_count = 0;
			mismatches <= 0;
			pending <= 0;
			words_checked <= 0;
		end else begin
			if (result_valid) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					$display("%0t: random_word %08h with no draw outstanding, expected none",
						$time, random_word);
				end else begin
					want = expected_words.pop_front();
					checked_count++;
					if (random_word !== want) begin
						fail_count++;
						$display("%0t: random_word expected %08h, got %08h",
							$time, want, random_word);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TWIST_MATRIX:  twist_reg = cfg_data;
					CFG_TEMPER_MASK_B: mask_b_reg = cfg_data;
					CFG_TEMPER_MASK_C: mask_c_reg = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (operation == OP_SEED) begin
					fill_from_seed(seed_value);
				end else begin
					if (next_read >= STATE_WORDS)
						twist_all();
					expected_words.push_back(temper_word(store_copy[next_read]));
					next_read++;
				end
			end
			mismatches <= fail_count;
			pending <= expected_words.size();
			words_checked <= checked_count;
		end
	end

endmodule

`default_nettype wire

/* tb/tb_mersenne_twister_word_generator.sv */
`default_nettype none

module tb_mersenne_twister_word_generator import mtwg_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam int SETTLE_CYCLES = 700;
	localparam int DRAIN_CYCLES  = 3000;
	localparam int PHASE_ITEMS   = 3;
	localparam int LONG_RUN      = 626;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 operation;
	logic [31:0]          seed_value;
	logic                 result_valid;
	logic [31:0]          random_word;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	int mismatches;
	int pending;
	int words_checked;
	int seeds_sent;
	int draws_sent;
	int reg_writes;
	int settings_used;
	bit quiet;

	logic [31:0] corner_seeds [5] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
		32'h8000_0000, 32'h7FFF_FFFF};

	mersenne_twister_word_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.seed_value   (seed_value),
		.result_valid (result_valid),
		.random_word  (random_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mtwg_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.seed_value    (seed_value),
		.result_valid  (result_valid),
		.random_word   (random_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.words_checked (words_checked)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#100ms;
		$display("DONE: errors detected");
		$finish;
	end

	// hold start high until the word is taken; the caller lowers it
	task automatic issue_word(input logic op, input logic [31:0] seed);
		start <= 1'b1;
		operation <= op;
		seed_value <= seed;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (op == OP_SEED)
			seeds_sent++;
		else
			draws_sent++;
	endtask

	task automatic idle_gap();
		int n;
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			n = 0;
		else if (r < 92)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(15, 80);
		if (n > 0) begin
			start <= 1'b0;
			operation <= 1'($urandom);
			seed_value <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// a seed may still be filling after the last draw result
	task automatic settle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic program_regs(input logic [31:0] twist, input logic [31:0] mask_b,
		input logic [31:0] mask_c);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [31:0]          val [4];
		idx = '{CFG_TWIST_MATRIX, CFG_UNMAPPED, CFG_TEMPER_MASK_B, CFG_TEMPER_MASK_C};
		val = '{twist, $urandom, mask_b, mask_c};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			reg_writes++;
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic seed_run(input logic [31:0] seed, input int n);
		idle_gap();
		issue_word(OP_SEED, seed);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 40) == 0)
				drain_results();
			else
				idle_gap();
			issue_word(OP_DRAW, $urandom);
		end
	endtask

	initial begin
		int          items;
		int          n;
		logic [31:0] seed;
		start = 1'b0;
		operation = OP_SEED;
		seed_value = 32'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TWIST_MATRIX;
		cfg_data = 32'd0;
		arst_n = 1'b0;
		quiet = 1'b1;
		seeds_sent = 0;
		draws_sent = 0;
		reg_writes = 0;
		settings_used = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner seeds, back-to-back seeds, first draw forces a batch twist
		issue_word(OP_SEED, 32'h0000_0000);
		repeat (3) issue_word(OP_DRAW, 32'hFFFF_FFFF);
		issue_word(OP_SEED, 32'hFFFF_FFFF);
		repeat (2) issue_word(OP_DRAW, 32'h0000_0000);
		issue_word(OP_SEED, 32'h8000_0000);
		issue_word(OP_SEED, 32'h0000_0001);
		repeat (2) issue_word(OP_DRAW, $urandom);
		issue_word(OP_SEED, 32'h7FFF_FFFF);
		issue_word(OP_DRAW, $urandom);

		// run past one full batch so the second twist builds on the first
		quiet = 1'b0;
		seed_run($urandom, LONG_RUN);

		for (int p = 0; p < 4; p++) begin
			if (p > 0) begin
				settle();
				case (p)
					1: program_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
					2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
					default: program_regs($urandom, $urandom, $urandom);
				endcase
			end
			items = 0;
			while (items < PHASE_ITEMS) begin
				quiet = ($urandom_range(0, 3) == 0);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
				seed = ($urandom_range(0, 4) == 0) ? corner_seeds[$urandom_range(0, 4)] : $urandom;
				seed_run(seed, n);
				items += n + 1;
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d seeds and %0d draws, %0d words checked.",
			seeds_sent, draws_sent, words_checked);
		$display("Register settings used: %0d, register writes: %0d (unmapped index included).",
			settings_used, reg_writes);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
